// ===== rtl/core/generational_handle_allocator_top_defines.svh =====
// Assertion macros for the handle allocator.
// Used by the top level only; clocked on clk, disabled while arst_n is low.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GHA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("gha assertion failed");
`define GHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("gha assertion failed");
`else
`define GHA_ASSERT(lbl, prop)
`define GHA_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/gha_pkg.sv =====
// Shared types, constants and helpers for the handle allocator.
// No dependencies.
`timescale 1ns / 1ps
package gha_pkg;
	localparam int CAPACITY   = 1024;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = IDX_W + 1;
	localparam int VER_W      = 12;
	localparam int SCENE_W    = 16;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_CHECK   = 2'd2,
		OP_LOOKUP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_STK,
		B_VER,
		B_OUT
	} bstate_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [SCENE_W-1:0] handle_scene;
		logic [IDX_W-1:0]   handle_index;
		logic [VER_W-1:0]   handle_version;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [IDX_W-1:0]   out_index;
		logic [VER_W-1:0]   out_version;
		logic [SCENE_W-1:0] out_scene;
		logic [CNT_W-1:0]   live_total;
	} rsp_t;

	typedef struct packed {
		op_t              op;
		logic             scene_ok;
		logic [IDX_W-1:0] index;
		logic [VER_W-1:0] version;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] fresh_mark;
		logic [CNT_W-1:0] free_depth;
	} status_t;

	function automatic logic [VER_W-1:0] bump_version(input logic [VER_W-1:0] v);
		logic [VER_W-1:0] n;
		n = v + VER_W'(1);
		return (n == '0) ? VER_W'(1) : n;
	endfunction
endpackage

// ===== rtl/core/gha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/gha_front.sv =====
// Front end: takes request items, decodes the opcode and checks the scene.
// Depends on gha_pkg.
`timescale 1ns / 1ps
module gha_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  gha_pkg::req_t               req,
	input  logic [gha_pkg::SCENE_W-1:0] scene_id,
	output logic                        cmd_valid,
	input  logic                        cmd_full,
	output gha_pkg::cmd_t               cmd
);
	logic          valid_s1;
	gha_pkg::cmd_t cmd_s1;
	logic          accept;
	logic          xfer;

	assign xfer   = valid_s1 && !cmd_full;
	assign full   = valid_s1 && cmd_full;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (xfer) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= '{
				op:       gha_pkg::op_t'(req.opcode),
				scene_ok: (req.handle_scene == scene_id),
				index:    req.handle_index,
				version:  req.handle_version
			};
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;
endmodule

// ===== rtl/core/gha_cmdq.sv =====
// Short command queue between front end and back end.
// Depends on gha_pkg.
`timescale 1ns / 1ps
module gha_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_full,
	input  gha_pkg::cmd_t wr_cmd,
	output logic          rd_valid,
	input  logic          rd_pop,
	output gha_pkg::cmd_t rd_cmd
);
	gha_pkg::cmd_t                      entry_q [gha_pkg::CMDQ_DEPTH];
	logic [gha_pkg::CMDQ_PTR_W-1:0]     wptr_q;
	logic [gha_pkg::CMDQ_PTR_W-1:0]     rptr_q;
	logic [gha_pkg::CMDQ_CNT_W-1:0]     count_q;
	logic                               do_wr;
	logic                               do_rd;

	assign wr_full  = (count_q == gha_pkg::CMDQ_CNT_W'(gha_pkg::CMDQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_valid && !wr_full;
	assign do_rd    = rd_pop && rd_valid;
	assign rd_cmd   = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + gha_pkg::CMDQ_PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + gha_pkg::CMDQ_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + gha_pkg::CMDQ_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - gha_pkg::CMDQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= wr_cmd;
		end
	end
endmodule

// ===== rtl/core/gha_back.sv =====
// Back end: version table and free stack, executes one command at a time.
// Depends on gha_pkg and gha_ram.
`timescale 1ns / 1ps
module gha_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_pop,
	input  gha_pkg::cmd_t               cmd,
	input  logic [gha_pkg::SCENE_W-1:0] scene_id,
	output logic                        empty,
	input  logic                        pop,
	output gha_pkg::rsp_t               rsp,
	output gha_pkg::status_t            status
);
	localparam int IDX_W = gha_pkg::IDX_W;
	localparam int CNT_W = gha_pkg::CNT_W;
	localparam int VER_W = gha_pkg::VER_W;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(gha_pkg::CAPACITY);

	gha_pkg::bstate_t state_q, state_d;
	gha_pkg::op_t     op_q, op_d;
	logic             scene_ok_q, scene_ok_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [VER_W-1:0] hv_q, hv_d;
	logic [CNT_W-1:0] fresh_q, fresh_d;
	logic [CNT_W-1:0] depth_q, depth_d;
	logic [CNT_W-1:0] live_q, live_d;
	gha_pkg::rsp_t    pend_q, pend_d;
	gha_pkg::rsp_t    res_q;
	logic             res_valid_q;
	logic             res_load;

	logic             ver_we;
	logic [IDX_W-1:0] ver_waddr, ver_raddr;
	logic [VER_W-1:0] ver_wdata, ver_rdata, ver_bump;
	logic             stk_we;
	logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;
	logic [CNT_W-1:0] depth_m1;
	logic             in_range;
	logic             hv_valid;

	gha_ram #(.WIDTH(VER_W), .DEPTH(gha_pkg::CAPACITY)) u_ver_ram (
		.clk   (clk),
		.we    (ver_we),
		.waddr (ver_waddr),
		.wdata (ver_wdata),
		.raddr (ver_raddr),
		.rdata (ver_rdata)
	);

	gha_ram #(.WIDTH(IDX_W), .DEPTH(gha_pkg::CAPACITY)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign depth_m1 = depth_q - CNT_W'(1);
	assign ver_bump = gha_pkg::bump_version(ver_rdata);
	// entries at or above the fresh mark were never written
	assign in_range = ({1'b0, idx_q} < fresh_q) && (ver_rdata != '0);
	assign hv_valid = scene_ok_q && in_range && (ver_rdata == hv_q);
	assign res_load = (state_q == gha_pkg::B_OUT) && (!res_valid_q || pop);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gha_pkg::B_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op != gha_pkg::OP_CREATE) begin
						state_d = gha_pkg::B_VER;
					end else if (depth_q != '0) begin
						state_d = gha_pkg::B_STK;
					end else begin
						state_d = gha_pkg::B_OUT;
					end
				end
			end
			gha_pkg::B_STK: state_d = gha_pkg::B_VER;
			gha_pkg::B_VER: state_d = gha_pkg::B_OUT;
			gha_pkg::B_OUT: begin
				if (res_load) begin
					state_d = gha_pkg::B_IDLE;
				end
			end
			default: state_d = gha_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		op_d       = op_q;
		scene_ok_d = scene_ok_q;
		idx_d      = idx_q;
		hv_d       = hv_q;
		fresh_d    = fresh_q;
		depth_d    = depth_q;
		live_d     = live_q;
		pend_d     = pend_q;
		ver_we     = 1'b0;
		ver_waddr  = idx_q;
		ver_wdata  = ver_bump;
		ver_raddr  = cmd.index;
		stk_we     = 1'b0;
		stk_waddr  = depth_q[IDX_W-1:0];
		stk_wdata  = idx_q;
		stk_raddr  = depth_m1[IDX_W-1:0];
		unique case (state_q)
			gha_pkg::B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop    = 1'b1;
					op_d       = cmd.op;
					scene_ok_d = cmd.scene_ok;
					idx_d      = cmd.index;
					hv_d       = cmd.version;
					pend_d     = '0;
					if (cmd.op == gha_pkg::OP_CREATE) begin
						if (depth_q != '0) begin
							depth_d = depth_m1;
						end else if (fresh_q < CAP) begin
							ver_we           = 1'b1;
							ver_waddr        = fresh_q[IDX_W-1:0];
							ver_wdata        = VER_W'(1);
							fresh_d          = fresh_q + CNT_W'(1);
							live_d           = (live_q < CAP) ? live_q + CNT_W'(1) : live_q;
							pend_d.ok        = 1'b1;
							pend_d.out_index = fresh_q[IDX_W-1:0];
							pend_d.out_version = VER_W'(1);
						end
					end
				end
			end
			gha_pkg::B_STK: begin
				ver_raddr = stk_rdata;
				idx_d     = stk_rdata;
			end
			gha_pkg::B_VER: begin
				case (op_q)
					gha_pkg::OP_CREATE: begin
						ver_we             = 1'b1;
						live_d             = (live_q < CAP) ? live_q + CNT_W'(1) : live_q;
						pend_d.ok          = 1'b1;
						pend_d.out_index   = idx_q;
						pend_d.out_version = ver_bump;
					end
					gha_pkg::OP_DESTROY: begin
						if (hv_valid) begin
							ver_we = 1'b1;
							if (depth_q < CAP) begin
								stk_we  = 1'b1;
								depth_d = depth_q + CNT_W'(1);
							end
							live_d             = (live_q != '0) ? live_q - CNT_W'(1) : live_q;
							pend_d.ok          = 1'b1;
							pend_d.out_index   = idx_q;
							pend_d.out_version = ver_bump;
						end
					end
					gha_pkg::OP_CHECK: begin
						if (hv_valid) begin
							pend_d.ok          = 1'b1;
							pend_d.out_index   = idx_q;
							pend_d.out_version = ver_rdata;
						end
					end
					default: begin
						if (in_range) begin
							pend_d.ok          = 1'b1;
							pend_d.out_index   = idx_q;
							pend_d.out_version = ver_rdata;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gha_pkg::B_IDLE;
			fresh_q     <= '0;
			depth_q     <= '0;
			live_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fresh_q <= fresh_d;
			depth_q <= depth_d;
			live_q  <= live_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		scene_ok_q <= scene_ok_d;
		idx_q      <= idx_d;
		hv_q       <= hv_d;
		pend_q     <= pend_d;
		if (res_load) begin
			res_q <= '{
				ok:          pend_q.ok,
				out_index:   pend_q.out_index,
				out_version: pend_q.out_version,
				out_scene:   scene_id,
				live_total:  live_q
			};
		end
	end

	assign empty             = !res_valid_q;
	assign rsp               = res_q;
	assign status.fresh_mark = fresh_q;
	assign status.free_depth = depth_q;
endmodule

// ===== rtl/core/generational_handle_allocator_top.sv =====
// A request passes the front-end register and command queue to the back-end sequencer.
// It takes a new command only after loading the last result, stepping around the
// registered-read version table (create from free stack needs a stack read first).
// Reset: asynchronous, arst_n low clears counters, queues and scene_id; version table
// and free stack are not cleared, the fresh mark gates every read so no clearing pass.
// Top level of the handle allocator; depends on gha_pkg, gha_front, gha_cmdq, gha_back.
`timescale 1ns / 1ps
`include "generational_handle_allocator_top_defines.svh"
module generational_handle_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  gha_pkg::req_t               req,
	output logic                        empty,
	input  logic                        pop,
	output gha_pkg::rsp_t               rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gha_pkg::SCENE_W-1:0] cfg_data
);
	logic [gha_pkg::SCENE_W-1:0] scene_q;
	logic                        f_valid, q_full, q_valid, q_pop;
	gha_pkg::cmd_t               f_cmd, q_cmd;
	gha_pkg::status_t            status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			scene_q <= cfg_data;
		end
	end

	gha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.scene_id  (scene_q),
		.cmd_valid (f_valid),
		.cmd_full  (q_full),
		.cmd       (f_cmd)
	);

	gha_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_full  (q_full),
		.wr_cmd   (f_cmd),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_cmd   (q_cmd)
	);

	gha_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd       (q_cmd),
		.scene_id  (scene_q),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.status    (status)
	);

	`GHA_ASSERT(a_counts_bounded, (status.fresh_mark <= gha_pkg::CNT_W'(gha_pkg::CAPACITY)) && (status.free_depth <= gha_pkg::CNT_W'(gha_pkg::CAPACITY)))
	`GHA_ASSERT_IMP(a_fail_zero, (!empty && !rsp.ok), (rsp.out_index == '0 && rsp.out_version == '0))
	`GHA_ASSERT_IMP(a_ok_version, (!empty && rsp.ok), (rsp.out_version != '0))
	`GHA_ASSERT_IMP(a_live_bounded, !empty, (rsp.live_total <= gha_pkg::CNT_W'(gha_pkg::CAPACITY)))
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for generational_handle_allocator_top: queue-style request and
// result ports, scene register written between phases. Needs gha_pkg and the RTL only.
`timescale 1ns / 1ps
module testbench;
	import gha_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	class handle_scoreboard;
		logic [VER_W-1:0]   version_of [CAPACITY];
		logic [IDX_W-1:0]   free_slots [CAPACITY];
		int                 free_depth;
		int                 fresh_mark;
		int                 live_count;
		logic [SCENE_W-1:0] scene;
		rsp_t               pending_replies [$];
		int                 faults;

		function new();
			foreach (version_of[i]) begin
				version_of[i] = '0;
				free_slots[i] = '0;
			end
			free_depth = 0;
			fresh_mark = 0;
			live_count = 0;
			scene = '0;
			faults = 0;
		endfunction

		function logic [VER_W-1:0] next_version(input logic [VER_W-1:0] v);
			logic [VER_W-1:0] n;
			n = v + VER_W'(1);
			return (n == '0) ? VER_W'(1) : n;
		endfunction

		function bit handle_valid(input req_t r);
			return r.handle_scene == scene && int'(r.handle_index) < fresh_mark
				&& version_of[r.handle_index] != '0
				&& version_of[r.handle_index] == r.handle_version;
		endfunction

		function void note_request(input req_t r);
			rsp_t want;
			int   slot;
			bit   got;
			want = '0;
			slot = int'(r.handle_index);
			got = 1'b0;
			case (op_t'(r.opcode))
			OP_CREATE: begin
				if (free_depth > 0) begin
					free_depth--;
					slot = int'(free_slots[free_depth]);
					version_of[slot] = next_version(version_of[slot]);
					got = 1'b1;
				end else if (fresh_mark < CAPACITY) begin
					slot = fresh_mark;
					fresh_mark++;
					version_of[slot] = VER_W'(1);
					got = 1'b1;
				end
				if (got && live_count < CAPACITY)
					live_count++;
			end
			OP_DESTROY: begin
				if (handle_valid(r)) begin
					version_of[slot] = next_version(version_of[slot]);
					if (free_depth < CAPACITY) begin
						free_slots[free_depth] = IDX_W'(slot);
						free_depth++;
					end
					if (live_count > 0)
						live_count--;
					got = 1'b1;
				end
			end
			OP_CHECK: begin
				got = handle_valid(r);
			end
			default: begin
				got = slot < fresh_mark && version_of[slot] != '0;
			end
			endcase
			if (got) begin
				want.ok = 1'b1;
				want.out_index = IDX_W'(slot);
				want.out_version = version_of[slot];
			end
			want.out_scene = scene;
			want.live_total = CNT_W'(live_count);
			pending_replies.insert(pending_replies.size(), want);
		endfunction

		function void check_response(input rsp_t got);
			rsp_t want;
			if (pending_replies.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: ok=%0d idx=%0d ver=%0d scene=%h live=%0d",
						got.ok, got.out_index, got.out_version, got.out_scene,
						got.live_total);
				return;
			end
			want = pending_replies.pop_front();
			if (got.ok !== want.ok || got.out_index !== want.out_index
					|| got.out_version !== want.out_version
					|| got.out_scene !== want.out_scene
					|| got.live_total !== want.live_total) begin
				faults++;
				if (faults <= 10)
					$display("result mismatch: expected ok=%0d idx=%0d ver=%0d scene=%h live=%0d, got ok=%0d idx=%0d ver=%0d scene=%h live=%0d",
						want.ok, want.out_index, want.out_version, want.out_scene,
						want.live_total, got.ok, got.out_index, got.out_version,
						got.out_scene, got.live_total);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	req_t               req = '0;
	logic               empty;
	logic               pop = 1'b0;
	rsp_t               rsp;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [SCENE_W-1:0] cfg_data = '0;

	handle_scoreboard sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_req = 0;
	int hold_left = 0;
	int quiet = 0;

	generational_handle_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// result side: check, then decide pop for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_response(rsp);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet == QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic req_t random_item();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[$bits(req_t)-1:0];
	endfunction

	function automatic req_t make_item(input op_t op, input logic [SCENE_W-1:0] scene,
			input int slot, input int ver);
		req_t item;
		item.opcode = op;
		item.handle_scene = scene;
		item.handle_index = IDX_W'(slot);
		item.handle_version = VER_W'(ver);
		return item;
	endfunction

	function automatic req_t create_item();
		req_t item;
		item = random_item();
		item.opcode = OP_CREATE;
		return item;
	endfunction

	// mostly well-formed handles taken from the live table, some near misses and noise
	function automatic req_t draw_item();
		req_t item;
		int   sel;
		int   slot;
		item = random_item();
		sel = $urandom_range(0, 99);
		if (sel < 12)
			return item;
		if (sel < 42 || sb.fresh_mark == 0) begin
			item.opcode = OP_CREATE;
			return item;
		end
		slot = $urandom_range(0, sb.fresh_mark - 1);
		item.handle_index = IDX_W'(slot);
		item.handle_scene = sb.scene;
		item.handle_version = sb.version_of[slot];
		if (sel < 64)
			item.opcode = OP_DESTROY;
		else if (sel < 78)
			item.opcode = OP_CHECK;
		else if (sel < 86)
			item.opcode = OP_LOOKUP;
		else begin
			item.opcode = $urandom_range(0, 1) ? OP_DESTROY : OP_CHECK;
			case ($urandom_range(0, 2))
			0: item.handle_version = item.handle_version
				+ ($urandom_range(0, 1) ? VER_W'(1) : '1);
			1: item.handle_scene = item.handle_scene ^ (SCENE_W'(1) << $urandom_range(0, 15));
			default: begin
				if (sb.fresh_mark < CAPACITY)
					item.handle_index = IDX_W'($urandom_range(sb.fresh_mark, CAPACITY - 1));
			end
			endcase
		end
		return item;
	endfunction

	task automatic send_item(input req_t item);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sb.note_request(item);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (sb.pending_replies.size() != 0);
	endtask

	task automatic write_scene(input logic [SCENE_W-1:0] scene);
		drain_results();
		repeat (8) @(posedge clk);
		cfg_data <= scene;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.scene = scene;
	endtask

	task automatic random_run(input int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2 && tx_idle_pct != 0)
				drain_results();
			send_item(draw_item());
		end
	endtask

	initial begin
		int slot;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then first slots, stale and repeated destroys, LIFO reuse
		send_item(make_item(OP_CHECK, 0, 0, 0));
		send_item(make_item(OP_LOOKUP, 0, 0, 0));
		send_item(make_item(OP_DESTROY, 0, 0, 0));
		send_item(make_item(OP_CREATE, 16'hFFFF, 1023, 4095));
		send_item(make_item(OP_CREATE, 0, 0, 0));
		send_item(make_item(OP_CHECK, 0, 0, 1));
		send_item(make_item(OP_CHECK, 16'hFFFF, 0, 1));
		send_item(make_item(OP_CHECK, 0, 0, 0));
		send_item(make_item(OP_LOOKUP, 16'hFFFF, 1, 4095));
		send_item(make_item(OP_LOOKUP, 0, 1023, 0));
		send_item(make_item(OP_DESTROY, 0, 0, 1));
		send_item(make_item(OP_DESTROY, 0, 0, 1));
		send_item(make_item(OP_DESTROY, 0, 0, 2));
		send_item(make_item(OP_DESTROY, 0, 1, 1));
		send_item(make_item(OP_CHECK, 0, 0, 3));
		send_item(make_item(OP_LOOKUP, 0, 0, 0));
		send_item(make_item(OP_CREATE, 0, 0, 0));
		send_item(make_item(OP_CREATE, 0, 0, 0));
		send_item(make_item(OP_CREATE, 0, 0, 0));
		send_item(make_item(OP_CREATE, 0, 0, 0));
		send_item(make_item(OP_CHECK, 16'hFFFF, 1023, 4095));
		send_item(make_item(OP_DESTROY, 16'hFFFF, 1023, 4095));

		write_scene(16'hFFFF);
		tx_idle_pct = 31;
		rx_idle_pct = 46;
		random_run(80);

		write_scene(SCENE_W'($urandom));
		tx_idle_pct = 46;
		rx_idle_pct = 31;
		random_run(80);

		write_scene('0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 300;

		// one slot destroyed over and over: duplicates pile up on the free stack
		slot = $urandom_range(0, sb.fresh_mark - 1);
		repeat (16)
			send_item(make_item(OP_DESTROY, sb.scene, slot, int'(sb.version_of[slot])));
		// drain the stack, then fill every fresh slot and run into a full table
		while (!(sb.fresh_mark == CAPACITY && sb.free_depth == 0))
			send_item(create_item());
		repeat (3) send_item(create_item());

		random_run(40);

		drain_results();
		repeat (16) @(posedge clk);
		if (sb.faults == 0 && sb.pending_replies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gha_pkg.sv
rtl/core/gha_ram.sv
rtl/core/gha_front.sv
rtl/core/gha_cmdq.sv
rtl/core/gha_back.sv
rtl/core/generational_handle_allocator_top.sv
bench/testbench.sv
